@@ sv/six_button_pad_reader_with_key_events_top_macros.svh @@
// Assertion helpers for the six-button pad reader.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SIX_BUTTON_PAD_READER_WITH_KEY_EVENTS_TOP_MACROS_SVH
`define SIX_BUTTON_PAD_READER_WITH_KEY_EVENTS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sbpr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbpr_pkg
// Types and constants shared by the six-button pad reader modules.
// ----------------------------------------------------------------------------
package sbpr_pkg;

	// Select phases the pad cycle runs through.
	localparam int PHASE_COUNT = 8;

	localparam int BUTTONS  = 12;
	localparam int MAP_W    = 13;
	localparam int PINS_W   = 6;
	localparam int TIME_W   = 32;
	localparam int CODE_W   = 7;
	localparam int DELAY_W  = 8;
	localparam int GAP_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Button map bit positions.
	localparam int BIT_UP        = 0;
	localparam int BIT_DOWN      = 1;
	localparam int BIT_LEFT      = 2;
	localparam int BIT_RIGHT     = 3;
	localparam int BIT_START     = 4;
	localparam int BIT_A         = 5;
	localparam int BIT_B         = 6;
	localparam int BIT_C         = 7;
	localparam int BIT_X         = 8;
	localparam int BIT_Y         = 9;
	localparam int BIT_Z         = 10;
	localparam int BIT_MODE      = 11;
	localparam int BIT_CONNECTED = 12;

	// Pin positions within one phase sample.
	localparam int PIN1 = 0;
	localparam int PIN2 = 1;
	localparam int PIN3 = 2;
	localparam int PIN4 = 3;
	localparam int PIN6 = 4;
	localparam int PIN9 = 5;

	// Key codes.
	localparam logic [CODE_W-1:0] KEY_LEFT  = 7'h40;
	localparam logic [CODE_W-1:0] KEY_RIGHT = 7'h41;
	localparam logic [CODE_W-1:0] KEY_UP    = 7'h42;
	localparam logic [CODE_W-1:0] KEY_DOWN  = 7'h43;
	localparam logic [CODE_W-1:0] KEY_START = 7'h44;
	localparam logic [CODE_W-1:0] KEY_MODE  = 7'h45;
	localparam logic [CODE_W-1:0] KEY_A     = 7'h46;
	localparam logic [CODE_W-1:0] KEY_B     = 7'h47;
	localparam logic [CODE_W-1:0] KEY_C     = 7'h48;
	localparam logic [CODE_W-1:0] KEY_X     = 7'h49;
	localparam logic [CODE_W-1:0] KEY_Y     = 7'h4a;
	localparam logic [CODE_W-1:0] KEY_Z     = 7'h4b;

	// Key code per map bit, in map bit order (also the priority order).
	localparam logic [CODE_W-1:0] KEY_CODE [BUTTONS] = '{
		KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_START, KEY_A,
		KEY_B, KEY_C, KEY_X, KEY_Y, KEY_Z, KEY_MODE
	};

	// Buttons debounced with the long gap: Y and Mode.
	localparam logic [BUTTONS-1:0] LONG_GAP_MASK =
		(BUTTONS'(1) << BIT_Y) | (BUTTONS'(1) << BIT_MODE);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_READ_DELAY = 2'd0,
		REG_SHORT_GAP  = 2'd1,
		REG_LONG_GAP   = 2'd2
	} cfg_reg_t;

	localparam logic [DELAY_W-1:0] READ_DELAY_RST = 8'd0;
	localparam logic [GAP_W-1:0]   SHORT_GAP_RST  = 16'd25;
	localparam logic [GAP_W-1:0]   LONG_GAP_RST   = 16'd50;

	typedef struct packed {
		logic [DELAY_W-1:0] read_delay;
		logic [GAP_W-1:0]   short_gap;
		logic [GAP_W-1:0]   long_gap;
	} cfg_t;

	typedef struct packed {
		logic [MAP_W-1:0]  button_map;
		logic              event_valid;
		logic [CODE_W-1:0] event_code;
		logic              event_press;
	} result_t;

endpackage

@@ sv/sbpr_cfg.sv @@
// ----------------------------------------------------------------------------
// sbpr_cfg
// Configuration register file: read delay and the two debounce gaps.
// ----------------------------------------------------------------------------
module sbpr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [sbpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sbpr_pkg::cfg_t                     cfg
);

	sbpr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_delay <= sbpr_pkg::READ_DELAY_RST;
			cfg_q.short_gap  <= sbpr_pkg::SHORT_GAP_RST;
			cfg_q.long_gap   <= sbpr_pkg::LONG_GAP_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				sbpr_pkg::REG_READ_DELAY: begin
					cfg_q.read_delay <= cfg_data[sbpr_pkg::DELAY_W-1:0];
				end
				sbpr_pkg::REG_SHORT_GAP: begin
					cfg_q.short_gap <= cfg_data[sbpr_pkg::GAP_W-1:0];
				end
				sbpr_pkg::REG_LONG_GAP: begin
					cfg_q.long_gap <= cfg_data[sbpr_pkg::GAP_W-1:0];
				end
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/sbpr_decode.sv @@
// ----------------------------------------------------------------------------
// sbpr_decode
// Turns the four active-low phase samples into a button map.
// ----------------------------------------------------------------------------
module sbpr_decode (
	input  logic [sbpr_pkg::PINS_W-1:0] pins_phase2,
	input  logic [sbpr_pkg::PINS_W-1:0] pins_phase3,
	input  logic [sbpr_pkg::PINS_W-1:0] pins_phase4,
	input  logic [sbpr_pkg::PINS_W-1:0] pins_phase5,
	output logic [sbpr_pkg::MAP_W-1:0]  fresh_map
);

	logic [sbpr_pkg::PINS_W-1:0] act2, act3, act4, act5;
	logic connected;
	logic six;

	assign act2 = ~pins_phase2;
	assign act3 = ~pins_phase3;
	assign act4 = ~pins_phase4;
	assign act5 = ~pins_phase5;

	assign connected = (sbpr_pkg::PHASE_COUNT > 2) &&
		act2[sbpr_pkg::PIN3] && act2[sbpr_pkg::PIN4];
	assign six = (sbpr_pkg::PHASE_COUNT > 4) &&
		act4[sbpr_pkg::PIN1] && act4[sbpr_pkg::PIN2];

	always_comb begin
		fresh_map = '0;
		fresh_map[sbpr_pkg::BIT_CONNECTED] = connected;
		fresh_map[sbpr_pkg::BIT_A]     = connected && act2[sbpr_pkg::PIN6];
		fresh_map[sbpr_pkg::BIT_START] = connected && act2[sbpr_pkg::PIN9];
		if (sbpr_pkg::PHASE_COUNT > 3) begin
			fresh_map[sbpr_pkg::BIT_UP]    = act3[sbpr_pkg::PIN1];
			fresh_map[sbpr_pkg::BIT_DOWN]  = act3[sbpr_pkg::PIN2];
			fresh_map[sbpr_pkg::BIT_LEFT]  = act3[sbpr_pkg::PIN3];
			fresh_map[sbpr_pkg::BIT_RIGHT] = act3[sbpr_pkg::PIN4];
			fresh_map[sbpr_pkg::BIT_B]     = act3[sbpr_pkg::PIN6];
			fresh_map[sbpr_pkg::BIT_C]     = act3[sbpr_pkg::PIN9];
		end
		// extra buttons only on a six-button pad
		if (six && (sbpr_pkg::PHASE_COUNT > 5)) begin
			fresh_map[sbpr_pkg::BIT_Z]    = act5[sbpr_pkg::PIN1];
			fresh_map[sbpr_pkg::BIT_Y]    = act5[sbpr_pkg::PIN2];
			fresh_map[sbpr_pkg::BIT_X]    = act5[sbpr_pkg::PIN3];
			fresh_map[sbpr_pkg::BIT_MODE] = act5[sbpr_pkg::PIN4];
		end
	end

endmodule

@@ sv/sbpr_event.sv @@
// ----------------------------------------------------------------------------
// sbpr_event
// Read-delay hold, change detection and debounced event pick; keeps the
// previous map and the last read and event times.
// ----------------------------------------------------------------------------
`include "six_button_pad_reader_with_key_events_top_macros.svh"

module sbpr_event (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [sbpr_pkg::TIME_W-1:0]  now_ms,
	input  logic [sbpr_pkg::MAP_W-1:0]   fresh_map,
	input  sbpr_pkg::cfg_t               cfg,
	output sbpr_pkg::result_t            res
);

	logic [sbpr_pkg::MAP_W-1:0]   prev_map_q;
	logic [sbpr_pkg::TIME_W-1:0]  last_read_q;
	logic [sbpr_pkg::TIME_W-1:0]  last_event_q;

	logic [sbpr_pkg::TIME_W-1:0]  since_read;
	logic [sbpr_pkg::TIME_W-1:0]  since_event;
	logic                         read_ok;
	logic                         pass_short;
	logic                         pass_long;
	logic [sbpr_pkg::MAP_W-1:0]   map;
	logic [sbpr_pkg::BUTTONS-1:0] changed;
	logic [sbpr_pkg::BUTTONS-1:0] gap_ok;
	logic [sbpr_pkg::BUTTONS-1:0] elig;
	logic [sbpr_pkg::BUTTONS-1:0] pick;
	logic [sbpr_pkg::CODE_W-1:0]  code;

	assign since_read  = now_ms - last_read_q;
	assign since_event = now_ms - last_event_q;
	assign read_ok     = since_read >=
		{{(sbpr_pkg::TIME_W-sbpr_pkg::DELAY_W){1'b0}}, cfg.read_delay};
	assign pass_short  = since_event >
		{{(sbpr_pkg::TIME_W-sbpr_pkg::GAP_W){1'b0}}, cfg.short_gap};
	assign pass_long   = since_event >
		{{(sbpr_pkg::TIME_W-sbpr_pkg::GAP_W){1'b0}}, cfg.long_gap};

	assign map     = read_ok ? fresh_map : prev_map_q;
	// connected bit never raises an event
	assign changed = map[sbpr_pkg::BUTTONS-1:0] ^ prev_map_q[sbpr_pkg::BUTTONS-1:0];
	assign gap_ok  = (sbpr_pkg::LONG_GAP_MASK & {sbpr_pkg::BUTTONS{pass_long}}) |
		(~sbpr_pkg::LONG_GAP_MASK & {sbpr_pkg::BUTTONS{pass_short}});
	assign elig    = changed & gap_ok;
	// isolate the lowest eligible button
	assign pick    = elig & (~elig + sbpr_pkg::BUTTONS'(1));

	always_comb begin
		code = '0;
		for (int i = 0; i < sbpr_pkg::BUTTONS; i++) begin
			code = code | (pick[i] ? sbpr_pkg::KEY_CODE[i] : '0);
		end
	end

	assign res.button_map  = map;
	assign res.event_valid = |elig;
	assign res.event_code  = code;
	assign res.event_press = |(pick & map[sbpr_pkg::BUTTONS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_map_q   <= '0;
			last_read_q  <= '0;
			last_event_q <= '0;
		end else if (step) begin
			prev_map_q <= map;
			if (read_ok) begin
				last_read_q <= now_ms;
			end
			if (res.event_valid) begin
				last_event_q <= now_ms;
			end
		end
	end

	`SBPR_ASSERT_NOW(a_one_pick, 1'b1, $onehot0(pick), "more than one button picked")
	`SBPR_ASSERT_NOW(a_hold_no_event, step && !read_ok,
		res.button_map == prev_map_q && !res.event_valid,
		"held map changed or raised an event")
	`SBPR_ASSERT_NEXT(a_gap_restart, step && res.event_valid,
		last_event_q == $past(now_ms), "debounce gap not restarted on event")

endmodule

@@ sv/six_button_pad_reader_with_key_events_top.sv @@
// ----------------------------------------------------------------------------
// six_button_pad_reader_with_key_events_top
// Six-button pad poll decoder with debounced press and release events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one poll per transfer: the
//   millisecond time and the active-low pin samples of select phases 2..5.
//   Output channel (out_valid/out_ready) gives one result per poll: the
//   button map and at most one key event.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect on the
//   same edge; write only while no poll is in flight.
//   A poll taken in sits in the poll register, then loads the result
//   register, from which it can transfer out.
//   Throughput: one poll per cycle while out_ready holds high; the path
//   from the poll register through decode, change detect and the
//   twelve-button priority pick to the result register is combinational.
//   Reset clears the previous map, both timestamps and the pipeline valids,
//   and loads the register reset values (read delay 0, gaps 25 and 50).
//   If the receiver stalls, the result register holds; the poll register
//   holds one more poll behind it, after which in_ready drops.
// ----------------------------------------------------------------------------
module six_button_pad_reader_with_key_events_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sbpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sbpr_pkg::TIME_W-1:0]       now_ms,
	input  logic [sbpr_pkg::PINS_W-1:0]       pins_phase2,
	input  logic [sbpr_pkg::PINS_W-1:0]       pins_phase3,
	input  logic [sbpr_pkg::PINS_W-1:0]       pins_phase4,
	input  logic [sbpr_pkg::PINS_W-1:0]       pins_phase5,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sbpr_pkg::MAP_W-1:0]        button_map,
	output logic                              event_valid,
	output logic [sbpr_pkg::CODE_W-1:0]       event_code,
	output logic                              event_press
);

	sbpr_pkg::cfg_t    cfg;
	sbpr_pkg::result_t res;
	sbpr_pkg::result_t res_q;
	logic              res_valid_q;

	logic                        valid_s1;
	logic [sbpr_pkg::TIME_W-1:0] now_s1;
	logic [sbpr_pkg::PINS_W-1:0] p2_s1, p3_s1, p4_s1, p5_s1;
	logic [sbpr_pkg::MAP_W-1:0]  fresh_map;

	logic adv;
	logic step;

	assign adv      = !res_valid_q || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	sbpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// poll register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1 <= now_ms;
			p2_s1  <= pins_phase2;
			p3_s1  <= pins_phase3;
			p4_s1  <= pins_phase4;
			p5_s1  <= pins_phase5;
		end
	end

	sbpr_decode u_decode (
		.pins_phase2 (p2_s1),
		.pins_phase3 (p3_s1),
		.pins_phase4 (p4_s1),
		.pins_phase5 (p5_s1),
		.fresh_map   (fresh_map)
	);

	sbpr_event u_event (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.now_ms    (now_s1),
		.fresh_map (fresh_map),
		.cfg       (cfg),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid   = res_valid_q;
	assign button_map  = res_q.button_map;
	assign event_valid = res_q.event_valid;
	assign event_code  = res_q.event_code;
	assign event_press = res_q.event_press;

endmodule

@@ bench/tb_six_button_pad_reader_with_key_events_top.sv @@
// ----------------------------------------------------------------------------
// tb_six_button_pad_reader_with_key_events_top
// Sends pad polls through the reader with random stalls on both channels.
// Each button map and key event is checked against a decoder and debounce
// tracker kept in this bench, under several register settings.
// ----------------------------------------------------------------------------
module tb_six_button_pad_reader_with_key_events_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [sbpr_pkg::TIME_W-1:0] now;
		logic [sbpr_pkg::PINS_W-1:0] p2;
		logic [sbpr_pkg::PINS_W-1:0] p3;
		logic [sbpr_pkg::PINS_W-1:0] p4;
		logic [sbpr_pkg::PINS_W-1:0] p5;
	} pad_poll_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_write = 1'b0;
	logic [sbpr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sbpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [sbpr_pkg::TIME_W-1:0]     now_ms = '0;
	logic [sbpr_pkg::PINS_W-1:0]     pins_phase2 = '1;
	logic [sbpr_pkg::PINS_W-1:0]     pins_phase3 = '1;
	logic [sbpr_pkg::PINS_W-1:0]     pins_phase4 = '1;
	logic [sbpr_pkg::PINS_W-1:0]     pins_phase5 = '1;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [sbpr_pkg::MAP_W-1:0]      button_map;
	logic                            event_valid;
	logic [sbpr_pkg::CODE_W-1:0]     event_code;
	logic                            event_press;

	// Reader state and registers as the bench tracks them.
	logic [sbpr_pkg::DELAY_W-1:0] trk_delay = sbpr_pkg::READ_DELAY_RST;
	logic [sbpr_pkg::GAP_W-1:0]   trk_short_gap = sbpr_pkg::SHORT_GAP_RST;
	logic [sbpr_pkg::GAP_W-1:0]   trk_long_gap = sbpr_pkg::LONG_GAP_RST;
	logic [sbpr_pkg::MAP_W-1:0]   trk_prev_map = '0;
	logic [sbpr_pkg::TIME_W-1:0]  trk_last_read = '0;
	logic [sbpr_pkg::TIME_W-1:0]  trk_last_event = '0;

	pad_poll_t                    polls_to_send[$];
	sbpr_pkg::result_t            pad_reports_due[$];
	pad_poll_t                    poll_on_bus;
	logic                         poll_pending = 1'b0;
	int                           idle_pct = 26;
	int                           mismatch_count = 0;
	int                           quiet_cycles = 0;
	logic [sbpr_pkg::TIME_W-1:0]  pad_clock = '0;
	logic [sbpr_pkg::BUTTONS-1:0] held_buttons = '0;

	six_button_pad_reader_with_key_events_top dut (.*);

	always #10 clk = ~clk;

	function automatic logic [sbpr_pkg::CODE_W-1:0] key_for_bit(int b);
		case (b)
			sbpr_pkg::BIT_UP:    return sbpr_pkg::KEY_UP;
			sbpr_pkg::BIT_DOWN:  return sbpr_pkg::KEY_DOWN;
			sbpr_pkg::BIT_LEFT:  return sbpr_pkg::KEY_LEFT;
			sbpr_pkg::BIT_RIGHT: return sbpr_pkg::KEY_RIGHT;
			sbpr_pkg::BIT_START: return sbpr_pkg::KEY_START;
			sbpr_pkg::BIT_A:     return sbpr_pkg::KEY_A;
			sbpr_pkg::BIT_B:     return sbpr_pkg::KEY_B;
			sbpr_pkg::BIT_C:     return sbpr_pkg::KEY_C;
			sbpr_pkg::BIT_X:     return sbpr_pkg::KEY_X;
			sbpr_pkg::BIT_Y:     return sbpr_pkg::KEY_Y;
			sbpr_pkg::BIT_Z:     return sbpr_pkg::KEY_Z;
			sbpr_pkg::BIT_MODE:  return sbpr_pkg::KEY_MODE;
			default:             return '0;
		endcase
	endfunction

	function automatic logic [sbpr_pkg::MAP_W-1:0] decode_pins(pad_poll_t p);
		logic [sbpr_pkg::MAP_W-1:0] m;
		m = '0;
		if (!p.p2[sbpr_pkg::PIN3] && !p.p2[sbpr_pkg::PIN4]) begin
			m[sbpr_pkg::BIT_CONNECTED] = 1'b1;
			m[sbpr_pkg::BIT_A]         = ~p.p2[sbpr_pkg::PIN6];
			m[sbpr_pkg::BIT_START]     = ~p.p2[sbpr_pkg::PIN9];
		end
		m[sbpr_pkg::BIT_UP]    = ~p.p3[sbpr_pkg::PIN1];
		m[sbpr_pkg::BIT_DOWN]  = ~p.p3[sbpr_pkg::PIN2];
		m[sbpr_pkg::BIT_LEFT]  = ~p.p3[sbpr_pkg::PIN3];
		m[sbpr_pkg::BIT_RIGHT] = ~p.p3[sbpr_pkg::PIN4];
		m[sbpr_pkg::BIT_B]     = ~p.p3[sbpr_pkg::PIN6];
		m[sbpr_pkg::BIT_C]     = ~p.p3[sbpr_pkg::PIN9];
		// six-button pads pull pins 1 and 2 low in phase 4
		if (!p.p4[sbpr_pkg::PIN1] && !p.p4[sbpr_pkg::PIN2]) begin
			m[sbpr_pkg::BIT_Z]    = ~p.p5[sbpr_pkg::PIN1];
			m[sbpr_pkg::BIT_Y]    = ~p.p5[sbpr_pkg::PIN2];
			m[sbpr_pkg::BIT_X]    = ~p.p5[sbpr_pkg::PIN3];
			m[sbpr_pkg::BIT_MODE] = ~p.p5[sbpr_pkg::PIN4];
		end
		return m;
	endfunction

	function automatic sbpr_pkg::result_t predict_poll(pad_poll_t p);
		logic [sbpr_pkg::MAP_W-1:0]  fresh;
		logic [sbpr_pkg::TIME_W-1:0] since_read;
		logic [sbpr_pkg::TIME_W-1:0] since_event;
		logic [sbpr_pkg::GAP_W-1:0]  gap;
		sbpr_pkg::result_t           r;
		fresh = trk_prev_map;
		since_read = p.now - trk_last_read;
		if (since_read >= sbpr_pkg::TIME_W'(trk_delay)) begin
			fresh = decode_pins(p);
			trk_last_read = p.now;
		end
		since_event = p.now - trk_last_event;
		r = '0;
		r.button_map = fresh;
		// first changed button in map order wins, the rest are dropped
		for (int b = 0; b < sbpr_pkg::BUTTONS; b++) begin
			gap = (b == sbpr_pkg::BIT_Y || b == sbpr_pkg::BIT_MODE) ?
				trk_long_gap : trk_short_gap;
			if (!r.event_valid && fresh[b] != trk_prev_map[b] &&
					since_event > sbpr_pkg::TIME_W'(gap)) begin
				r.event_valid = 1'b1;
				r.event_code  = key_for_bit(b);
				r.event_press = fresh[b];
				trk_last_event = p.now;
			end
		end
		trk_prev_map = fresh;
		return r;
	endfunction

	// Well-formed poll for a pad holding the given buttons; unused pins random.
	function automatic pad_poll_t make_poll(logic [sbpr_pkg::TIME_W-1:0] t,
			logic [sbpr_pkg::BUTTONS-1:0] btn, logic conn, logic six);
		pad_poll_t p;
		p.now = t;
		p.p2  = sbpr_pkg::PINS_W'($urandom);
		p.p3  = sbpr_pkg::PINS_W'($urandom);
		p.p4  = sbpr_pkg::PINS_W'($urandom);
		p.p5  = sbpr_pkg::PINS_W'($urandom);
		if (conn) begin
			p.p2[sbpr_pkg::PIN3] = 1'b0;
			p.p2[sbpr_pkg::PIN4] = 1'b0;
		end else if (!p.p2[sbpr_pkg::PIN3] && !p.p2[sbpr_pkg::PIN4]) begin
			p.p2[sbpr_pkg::PIN3 + $urandom_range(1)] = 1'b1;
		end
		p.p2[sbpr_pkg::PIN6] = ~btn[sbpr_pkg::BIT_A];
		p.p2[sbpr_pkg::PIN9] = ~btn[sbpr_pkg::BIT_START];
		p.p3[sbpr_pkg::PIN1] = ~btn[sbpr_pkg::BIT_UP];
		p.p3[sbpr_pkg::PIN2] = ~btn[sbpr_pkg::BIT_DOWN];
		p.p3[sbpr_pkg::PIN3] = ~btn[sbpr_pkg::BIT_LEFT];
		p.p3[sbpr_pkg::PIN4] = ~btn[sbpr_pkg::BIT_RIGHT];
		p.p3[sbpr_pkg::PIN6] = ~btn[sbpr_pkg::BIT_B];
		p.p3[sbpr_pkg::PIN9] = ~btn[sbpr_pkg::BIT_C];
		if (six) begin
			p.p4[sbpr_pkg::PIN1] = 1'b0;
			p.p4[sbpr_pkg::PIN2] = 1'b0;
		end else if (!p.p4[sbpr_pkg::PIN1] && !p.p4[sbpr_pkg::PIN2]) begin
			p.p4[sbpr_pkg::PIN1 + $urandom_range(1)] = 1'b1;
		end
		p.p5[sbpr_pkg::PIN1] = ~btn[sbpr_pkg::BIT_Z];
		p.p5[sbpr_pkg::PIN2] = ~btn[sbpr_pkg::BIT_Y];
		p.p5[sbpr_pkg::PIN3] = ~btn[sbpr_pkg::BIT_X];
		p.p5[sbpr_pkg::PIN4] = ~btn[sbpr_pkg::BIT_MODE];
		return p;
	endfunction

	task automatic queue_random_polls(int n);
		pad_poll_t p;
		int        r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 10)
				;
			else if (r < 85)
				pad_clock += $urandom_range(1, 40);
			else if (r < 95)
				pad_clock += $urandom_range(41, 400);
			else
				pad_clock += $urandom;
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(99) < 40)
					held_buttons ^= sbpr_pkg::BUTTONS'(1) <<
						$urandom_range(sbpr_pkg::BUTTONS - 1);
				if ($urandom_range(99) < 15)
					held_buttons ^= sbpr_pkg::BUTTONS'(1) <<
						$urandom_range(sbpr_pkg::BUTTONS - 1);
				p = make_poll(pad_clock, held_buttons, $urandom_range(99) < 95,
					$urandom_range(99) < 90);
			end else begin
				// noise: arbitrary pin levels
				p.now = pad_clock;
				p.p2  = sbpr_pkg::PINS_W'($urandom);
				p.p3  = sbpr_pkg::PINS_W'($urandom);
				p.p4  = sbpr_pkg::PINS_W'($urandom);
				p.p5  = sbpr_pkg::PINS_W'($urandom);
			end
			polls_to_send.push_back(p);
		end
	endtask

	task automatic wait_until_drained();
		do
			@(posedge clk);
		while (polls_to_send.size() != 0 || poll_pending || pad_reports_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(sbpr_pkg::cfg_reg_t idx, logic [sbpr_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			sbpr_pkg::REG_READ_DELAY: trk_delay = value[sbpr_pkg::DELAY_W-1:0];
			sbpr_pkg::REG_SHORT_GAP:  trk_short_gap = value;
			sbpr_pkg::REG_LONG_GAP:   trk_long_gap = value;
			default: ;
		endcase
	endtask

	task automatic set_registers(logic [sbpr_pkg::DELAY_W-1:0] delay_ms,
			logic [sbpr_pkg::GAP_W-1:0] short_ms, logic [sbpr_pkg::GAP_W-1:0] long_ms);
		// upper data bits are not part of the read delay
		write_reg(sbpr_pkg::REG_READ_DELAY, {8'($urandom), delay_ms});
		write_reg(sbpr_pkg::REG_SHORT_GAP, short_ms);
		write_reg(sbpr_pkg::REG_LONG_GAP, long_ms);
	endtask

	// Poll driver: predict on each transfer, then load the next poll or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pad_reports_due.push_back(predict_poll(poll_on_bus));
				poll_pending = 1'b0;
			end
			if (!in_valid || in_ready) begin
				if (polls_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
					poll_on_bus = polls_to_send.pop_front();
					poll_pending = 1'b1;
					in_valid    <= 1'b1;
					now_ms      <= poll_on_bus.now;
					pins_phase2 <= poll_on_bus.p2;
					pins_phase3 <= poll_on_bus.p3;
					pins_phase4 <= poll_on_bus.p4;
					pins_phase5 <= poll_on_bus.p5;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		sbpr_pkg::result_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pad_reports_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result with no poll outstanding: map %h event %b/%h/%b",
							button_map, event_valid, event_code, event_press);
				end else begin
					due = pad_reports_due.pop_front();
					if (button_map !== due.button_map || event_valid !== due.event_valid ||
							event_code !== due.event_code ||
							event_press !== due.event_press) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display({"mismatch: map exp %h got %h, event exp %b/%h/%b",
								" got %b/%h/%b"}, due.button_map, button_map,
								due.event_valid, due.event_code, due.event_press,
								event_valid, event_code, event_press);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [sbpr_pkg::BUTTONS-1:0] btn;
		logic [sbpr_pkg::TIME_W-1:0]  t;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// all released, then all pressed inside the gap, then all released past it
		polls_to_send.push_back({32'd0, {4{6'h3f}}});
		polls_to_send.push_back({32'd0, {4{6'h00}}});
		polls_to_send.push_back({32'd26, {4{6'h00}}});
		polls_to_send.push_back({32'd27, {4{6'h3f}}});
		polls_to_send.push_back({32'd40, {4{6'h00}}});
		polls_to_send.push_back({32'd53, {4{6'h00}}});
		t = 32'd120;
		polls_to_send.push_back(make_poll(t, '0, 1'b1, 1'b1));
		// press one more button per poll so every key code shows up
		btn = '0;
		for (int b = 0; b < sbpr_pkg::BUTTONS; b++) begin
			btn[b] = 1'b1;
			t += 60;
			polls_to_send.push_back(make_poll(t, btn, 1'b1, 1'b1));
		end
		t += 60;
		polls_to_send.push_back(make_poll(t, '0, 1'b1, 1'b1));
		// unplug only: connected bit changes alone
		t += 60;
		polls_to_send.push_back(make_poll(t, '0, 1'b0, 1'b1));
		// time wraps between these two
		polls_to_send.push_back(make_poll(32'hFFFF_FFF0, '0, 1'b1, 1'b1));
		held_buttons = sbpr_pkg::BUTTONS'(1) << sbpr_pkg::BIT_UP;
		pad_clock = 32'h0000_0010;
		polls_to_send.push_back(make_poll(pad_clock, held_buttons, 1'b1, 1'b1));
		wait_until_drained();

		// hold the sender midway until every result is back
		queue_random_polls(135);
		wait_until_drained();
		queue_random_polls(135);
		wait_until_drained();

		set_registers(8'd0, 16'd0, 16'd0);
		idle_pct = 0;
		queue_random_polls(210);
		wait_until_drained();
		idle_pct = 26;

		set_registers(8'd255, 16'hFFFF, 16'hFFFF);
		queue_random_polls(210);
		wait_until_drained();

		set_registers(8'd10, 16'd5, 16'd30);
		queue_random_polls(210);
		wait_until_drained();

		set_registers(8'($urandom), 16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)));
		queue_random_polls(210);
		wait_until_drained();

		set_registers(8'($urandom_range(0, 20)), 16'($urandom_range(0, 60)),
			16'($urandom_range(0, 60)));
		queue_random_polls(210);
		wait_until_drained();

		if (mismatch_count == 0 && pad_reports_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
